// File: design/deadband_pid_valve_drive_macros.svh
// Assertion macros for the deadband PID valve drive.
`ifndef DEADBAND_PID_VALVE_DRIVE_MACROS_SVH
`define DEADBAND_PID_VALVE_DRIVE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DPVD_ASSERT_SAME(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("deadband_pid_valve_drive: same-cycle check failed");

`define DPVD_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("deadband_pid_valve_drive: next-cycle check failed");

`else

`define DPVD_ASSERT_SAME(label, ck, rn, ante, cons)

`define DPVD_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

// File: design/dpvd_pkg.sv
// Shared types, constants and micro-op codes of the deadband PID valve drive.
package dpvd_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [2:0] REG_BAND          = 3'd3;
	localparam logic [2:0] REG_RETRACT_START = 3'd4;
	localparam logic [2:0] REG_EXTEND_START  = 3'd5;
	localparam logic [2:0] REG_RETRACT_LIMIT = 3'd6;
	localparam logic [2:0] REG_EXTEND_LIMIT  = 3'd7;

	localparam logic [15:0] RST_PROP_GAIN     = 16'd11520;
	localparam logic [15:0] RST_INTEG_GAIN    = 16'd1311;
	localparam logic [15:0] RST_DERIV_GAIN    = 16'd3100;
	localparam logic [7:0]  RST_BAND          = 8'd0;
	localparam logic [11:0] RST_RETRACT_START = 12'd1845;
	localparam logic [11:0] RST_EXTEND_START  = 12'd2250;
	localparam logic [11:0] RST_RETRACT_LIMIT = 12'd450;
	localparam logic [11:0] RST_EXTEND_LIMIT  = 12'd3645;

	localparam logic [1:0] DIR_RAISE = 2'd0;
	localparam logic [1:0] DIR_LOWER = 2'd1;
	localparam logic [1:0] DIR_HOLD  = 2'd2;
	localparam logic [1:0] DIR_IDLE  = 2'd3;

	localparam logic [11:0] FLOAT_CODE = 12'd2048;
	localparam int TOTAL_LIMIT = 2300;
	localparam int DIFF_DIV    = 50;
	localparam int Q16_ONE     = 65536;

	localparam int ERR_W   = 11;
	localparam int MA_W    = 25;
	localparam int MB_W    = 22;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int INTEG_W = 48;
	localparam int ACC_W   = INTEG_W + 1;
	localparam int TOT_W   = 57;
	localparam int X_W     = 17;
	localparam int T_W     = 13;
	localparam int M_W     = 24;
	localparam int Q_W     = 12;
	localparam int CODE_W  = 14;

	localparam longint TOT_LIMIT_RAW = longint'(TOTAL_LIMIT) * DIFF_DIV * Q16_ONE;
	localparam logic signed [TOT_W-1:0] TOT_MAX = TOT_W'(TOT_LIMIT_RAW);

	localparam int RECIP_DIFF_SH = 22;
	localparam logic [MB_W-1:0] RECIP_DIFF = MB_W'((longint'(1) << RECIP_DIFF_SH) / DIFF_DIV);
	localparam int RECIP_LIM_SH = 32;
	localparam logic [MB_W-1:0] RECIP_LIM = MB_W'((longint'(1) << RECIP_LIM_SH) / TOTAL_LIMIT);

	typedef logic [3:0] op_t;

	localparam op_t OP_NONE  = 4'd0;
	localparam op_t OP_MUL_I = 4'd1;
	localparam op_t OP_MUL_P = 4'd2;
	localparam op_t OP_MUL_D = 4'd3;
	localparam op_t OP_SCALE = 4'd4;
	localparam op_t OP_TOTAL = 4'd5;
	localparam op_t OP_SAT   = 4'd6;
	localparam op_t OP_MUL_Q = 4'd7;
	localparam op_t OP_DIV_Q = 4'd8;
	localparam op_t OP_MUL_M = 4'd9;
	localparam op_t OP_ABS   = 4'd10;
	localparam op_t OP_MUL_R = 4'd11;
	localparam op_t OP_DIV_R = 4'd12;
	localparam op_t OP_MUL_C = 4'd13;
	localparam op_t OP_CORR  = 4'd14;
	localparam op_t OP_MAP   = 4'd15;

	typedef struct packed {
		logic        load;
		op_t         op;
		logic        out_load;
	} cmd_t;

	typedef struct packed {
		logic        active;
	} stat_t;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [15:0] deriv_gain;
		logic [7:0]  band;
		logic [11:0] retract_start;
		logic [11:0] extend_start;
		logic [11:0] retract_limit;
		logic [11:0] extend_limit;
	} cfg_t;

endpackage

// File: design/dpvd_tick_if.sv
// Handshake channel that carries one control tick item.
interface dpvd_tick_if;
	logic       valid;
	logic       ready;
	logic [1:0] direction;
	logic       auto_mode;
	logic [9:0] cut_depth;
	logic       link_ok;

	modport source (output valid, direction, auto_mode, cut_depth, link_ok, input ready);
	modport sink (input valid, direction, auto_mode, cut_depth, link_ok, output ready);
endinterface

// File: design/dpvd_drive_if.sv
// Handshake channel that carries one valve drive result item.
interface dpvd_drive_if;
	logic        valid;
	logic        ready;
	logic [11:0] drive_code;
	logic        drive_write;

	modport source (output valid, drive_code, drive_write, input ready);
	modport sink (input valid, drive_code, drive_write, output ready);
endinterface

// File: design/dpvd_regs.sv
// APB configuration register file of the valve drive.
module dpvd_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dpvd_pkg::ADDR_W-1:0]  paddr,
	input  logic [dpvd_pkg::DATA_W-1:0]  pwdata,
	output logic [dpvd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output dpvd_pkg::cfg_t               cfg
);
	localparam int DATA_W = dpvd_pkg::DATA_W;
	localparam int ADDR_W = dpvd_pkg::ADDR_W;

	dpvd_pkg::cfg_t cfg_q;
	logic [ADDR_W-3:0] index;
	logic wr_en;

	assign index = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= dpvd_pkg::RST_PROP_GAIN;
			cfg_q.integ_gain    <= dpvd_pkg::RST_INTEG_GAIN;
			cfg_q.deriv_gain    <= dpvd_pkg::RST_DERIV_GAIN;
			cfg_q.band          <= dpvd_pkg::RST_BAND;
			cfg_q.retract_start <= dpvd_pkg::RST_RETRACT_START;
			cfg_q.extend_start  <= dpvd_pkg::RST_EXTEND_START;
			cfg_q.retract_limit <= dpvd_pkg::RST_RETRACT_LIMIT;
			cfg_q.extend_limit  <= dpvd_pkg::RST_EXTEND_LIMIT;
		end else if (wr_en) begin
			unique case (index)
				dpvd_pkg::REG_PROP_GAIN:     cfg_q.prop_gain     <= pwdata[15:0];
				dpvd_pkg::REG_INTEG_GAIN:    cfg_q.integ_gain    <= pwdata[15:0];
				dpvd_pkg::REG_DERIV_GAIN:    cfg_q.deriv_gain    <= pwdata[15:0];
				dpvd_pkg::REG_BAND:          cfg_q.band          <= pwdata[7:0];
				dpvd_pkg::REG_RETRACT_START: cfg_q.retract_start <= pwdata[11:0];
				dpvd_pkg::REG_EXTEND_START:  cfg_q.extend_start  <= pwdata[11:0];
				dpvd_pkg::REG_RETRACT_LIMIT: cfg_q.retract_limit <= pwdata[11:0];
				dpvd_pkg::REG_EXTEND_LIMIT:  cfg_q.extend_limit  <= pwdata[11:0];
			endcase
		end
	end

	always_comb begin
		unique case (index)
			dpvd_pkg::REG_PROP_GAIN:     prdata = DATA_W'(cfg_q.prop_gain);
			dpvd_pkg::REG_INTEG_GAIN:    prdata = DATA_W'(cfg_q.integ_gain);
			dpvd_pkg::REG_DERIV_GAIN:    prdata = DATA_W'(cfg_q.deriv_gain);
			dpvd_pkg::REG_BAND:          prdata = DATA_W'(cfg_q.band);
			dpvd_pkg::REG_RETRACT_START: prdata = DATA_W'(cfg_q.retract_start);
			dpvd_pkg::REG_EXTEND_START:  prdata = DATA_W'(cfg_q.extend_start);
			dpvd_pkg::REG_RETRACT_LIMIT: prdata = DATA_W'(cfg_q.retract_limit);
			dpvd_pkg::REG_EXTEND_LIMIT:  prdata = DATA_W'(cfg_q.extend_limit);
		endcase
	end
endmodule

// File: design/dpvd_ctrl.sv
// Sequencer that steps the datapath through one control tick and owns the handshakes.
module dpvd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  dpvd_pkg::stat_t stat,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output dpvd_pkg::cmd_t  cmd
);
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_MUL_I = 5'd1;
	localparam logic [4:0] ST_MUL_P = 5'd2;
	localparam logic [4:0] ST_MUL_D = 5'd3;
	localparam logic [4:0] ST_SCALE = 5'd4;
	localparam logic [4:0] ST_TOTAL = 5'd5;
	localparam logic [4:0] ST_SAT   = 5'd6;
	localparam logic [4:0] ST_MUL_Q = 5'd7;
	localparam logic [4:0] ST_DIV_Q = 5'd8;
	localparam logic [4:0] ST_MUL_M = 5'd9;
	localparam logic [4:0] ST_ABS   = 5'd10;
	localparam logic [4:0] ST_MUL_R = 5'd11;
	localparam logic [4:0] ST_DIV_R = 5'd12;
	localparam logic [4:0] ST_MUL_C = 5'd13;
	localparam logic [4:0] ST_CORR  = 5'd14;
	localparam logic [4:0] ST_MAP   = 5'd15;
	localparam logic [4:0] ST_DONE  = 5'd16;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.op = dpvd_pkg::OP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.op = dpvd_pkg::OP_MUL_I;
				state_d = stat.active ? ST_MUL_P : ST_DONE;
			end
			ST_MUL_P: begin
				cmd.op = dpvd_pkg::OP_MUL_P;
				state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.op = dpvd_pkg::OP_MUL_D;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.op = dpvd_pkg::OP_SCALE;
				state_d = ST_TOTAL;
			end
			ST_TOTAL: begin
				cmd.op = dpvd_pkg::OP_TOTAL;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				cmd.op = dpvd_pkg::OP_SAT;
				state_d = ST_MUL_Q;
			end
			ST_MUL_Q: begin
				cmd.op = dpvd_pkg::OP_MUL_Q;
				state_d = ST_DIV_Q;
			end
			ST_DIV_Q: begin
				cmd.op = dpvd_pkg::OP_DIV_Q;
				state_d = ST_MUL_M;
			end
			ST_MUL_M: begin
				cmd.op = dpvd_pkg::OP_MUL_M;
				state_d = ST_ABS;
			end
			ST_ABS: begin
				cmd.op = dpvd_pkg::OP_ABS;
				state_d = ST_MUL_R;
			end
			ST_MUL_R: begin
				cmd.op = dpvd_pkg::OP_MUL_R;
				state_d = ST_DIV_R;
			end
			ST_DIV_R: begin
				cmd.op = dpvd_pkg::OP_DIV_R;
				state_d = ST_MUL_C;
			end
			ST_MUL_C: begin
				cmd.op = dpvd_pkg::OP_MUL_C;
				state_d = ST_CORR;
			end
			ST_CORR: begin
				cmd.op = dpvd_pkg::OP_CORR;
				state_d = ST_MAP;
			end
			ST_MAP: begin
				cmd.op = dpvd_pkg::OP_MAP;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.out_load = out_free;
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: design/dpvd_dp.sv
// Datapath of the valve drive: PID terms on one shared multiplier, scaling, mapping, clamp.
module dpvd_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  dpvd_pkg::cfg_t  cfg,
	input  dpvd_pkg::cmd_t  cmd,
	output dpvd_pkg::stat_t stat,
	input  logic [1:0]      direction,
	input  logic            auto_mode,
	input  logic [9:0]      cut_depth,
	input  logic            link_ok,
	output logic [11:0]     drive_code,
	output logic            drive_write
);
	localparam int ERR_W   = dpvd_pkg::ERR_W;
	localparam int MA_W    = dpvd_pkg::MA_W;
	localparam int MB_W    = dpvd_pkg::MB_W;
	localparam int PROD_W  = dpvd_pkg::PROD_W;
	localparam int INTEG_W = dpvd_pkg::INTEG_W;
	localparam int ACC_W   = dpvd_pkg::ACC_W;
	localparam int TOT_W   = dpvd_pkg::TOT_W;
	localparam int X_W     = dpvd_pkg::X_W;
	localparam int T_W     = dpvd_pkg::T_W;
	localparam int M_W     = dpvd_pkg::M_W;
	localparam int Q_W     = dpvd_pkg::Q_W;
	localparam int CODE_W  = dpvd_pkg::CODE_W;
	localparam int Q_SH    = $clog2(dpvd_pkg::Q16_ONE);
	localparam int P_SH    = 8;

	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
	localparam logic signed [T_W-1:0] T_LIM = T_W'(dpvd_pkg::TOTAL_LIMIT);

	logic [1:0]                 dir_q;
	logic [9:0]                 depth_q;
	logic                       active_q;
	logic signed [ERR_W-1:0]    err_q;
	logic signed [ERR_W-1:0]    prev_q;
	logic signed [INTEG_W-1:0]  integ_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [TOT_W-1:0]    tot_q;
	logic                       sat_q;
	logic                       neg_q;
	logic [X_W-1:0]             x_q;
	logic signed [T_W-1:0]      t_q;
	logic [M_W-1:0]             m_q;
	logic                       pneg_q;
	logic [Q_W-1:0]             qd_q;
	logic signed [CODE_W-1:0]   code_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic [11:0]                drive_code_q;
	logic                       drive_write_q;

	logic signed [ERR_W-1:0]    load_err;
	logic signed [ERR_W:0]      err_w;
	logic signed [ERR_W:0]      band_s;
	logic                       in_window;
	logic signed [ERR_W:0]      diff;
	logic [11:0]                start_sel;
	logic [11:0]                limit_sel;
	logic signed [12:0]         span;
	logic signed [MA_W-1:0]     mul_a;
	logic signed [MB_W-1:0]     mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic                       mul_en;
	logic signed [INTEG_W:0]    integ_sum;
	logic signed [INTEG_W-1:0]  integ_next;
	logic signed [TOT_W-1:0]    acc_w;
	logic [TOT_W-1:0]           tot_abs;
	logic [Q_W-1:0]             q0;
	logic [X_W-1:0]             q0_w;
	logic [X_W-1:0]             q50;
	logic [X_W-1:0]             r50;
	logic [Q_W-1:0]             qc;
	logic signed [T_W-1:0]      qc_s;
	logic signed [PROD_W-1:0]   prod_abs;
	logic [M_W:0]               rl;
	logic signed [CODE_W-1:0]   qd_s;
	logic signed [CODE_W-1:0]   start_s;
	logic signed [CODE_W-1:0]   ext_s;
	logic signed [CODE_W-1:0]   ret_s;
	logic signed [CODE_W-1:0]   clamp_hi;
	logic signed [CODE_W-1:0]   clamp_lo;
	logic [11:0]                res_code;
	logic                       res_write;

	assign load_err = (direction == dpvd_pkg::DIR_RAISE) ? signed'({1'b0, cut_depth})
		: -signed'({1'b0, cut_depth});

	assign err_w = (ERR_W+1)'(err_q);
	assign band_s = signed'({4'b0, cfg.band});
	assign in_window = (err_w > -band_s) && (err_w < band_s);
	assign diff = (ERR_W+1)'(err_q) - (ERR_W+1)'(prev_q);

	assign start_sel = (dir_q == dpvd_pkg::DIR_LOWER) ? cfg.retract_start : cfg.extend_start;
	assign limit_sel = (dir_q == dpvd_pkg::DIR_LOWER) ? cfg.retract_limit : cfg.extend_limit;
	assign span = signed'({1'b0, limit_sel}) - signed'({1'b0, start_sel});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_en = 1'b1;
		unique case (cmd.op)
			dpvd_pkg::OP_MUL_I: begin
				mul_a = signed'(MA_W'(cfg.integ_gain));
				mul_b = MB_W'(err_q);
			end
			dpvd_pkg::OP_MUL_P: begin
				mul_a = signed'(MA_W'(cfg.prop_gain));
				mul_b = MB_W'(err_q);
			end
			dpvd_pkg::OP_MUL_D: begin
				mul_a = signed'(MA_W'(cfg.deriv_gain));
				mul_b = MB_W'(diff);
			end
			dpvd_pkg::OP_MUL_Q: begin
				mul_a = signed'(MA_W'(x_q));
				mul_b = signed'(dpvd_pkg::RECIP_DIFF);
			end
			dpvd_pkg::OP_MUL_M: begin
				mul_a = MA_W'(t_q);
				mul_b = MB_W'(span);
			end
			dpvd_pkg::OP_MUL_R: begin
				mul_a = signed'(MA_W'(m_q));
				mul_b = signed'(dpvd_pkg::RECIP_LIM);
			end
			dpvd_pkg::OP_MUL_C: begin
				mul_a = signed'(MA_W'(qd_q));
				mul_b = MB_W'(dpvd_pkg::TOTAL_LIMIT);
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(prod_q);
	assign integ_next = (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
		? (integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX) : integ_sum[INTEG_W-1:0];

	assign acc_w = TOT_W'(acc_q);
	assign tot_abs = tot_q[TOT_W-1] ? unsigned'(-tot_q) : unsigned'(tot_q);

	assign q0 = prod_q[dpvd_pkg::RECIP_DIFF_SH+Q_W-1:dpvd_pkg::RECIP_DIFF_SH];
	assign q0_w = X_W'(q0);
	assign q50 = (q0_w << 5) + (q0_w << 4) + (q0_w << 1);
	assign r50 = x_q - q50;
	assign qc = q0 + Q_W'(r50 >= X_W'(dpvd_pkg::DIFF_DIV));
	assign qc_s = signed'({1'b0, qc});

	assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign rl = {1'b0, m_q} - prod_q[M_W:0];

	assign qd_s = signed'({2'b0, qd_q});
	assign start_s = signed'({2'b0, start_sel});
	assign ext_s = signed'({2'b0, cfg.extend_limit});
	assign ret_s = signed'({2'b0, cfg.retract_limit});
	assign clamp_hi = (code_q >= ext_s) ? ext_s : code_q;
	assign clamp_lo = (clamp_hi <= ret_s) ? ret_s : clamp_hi;

	always_comb begin
		priority if (!active_q) begin
			res_code = dpvd_pkg::FLOAT_CODE;
			res_write = 1'b1;
		end else if (depth_q < {2'b0, cfg.band}) begin
			res_code = dpvd_pkg::FLOAT_CODE;
			res_write = 1'b0;
		end else begin
			res_code = clamp_lo[11:0];
			res_write = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q <= '0;
		end else begin
			if (cmd.op == dpvd_pkg::OP_MUL_P) begin
				integ_q <= in_window ? integ_next : '0;
			end
			if (cmd.op == dpvd_pkg::OP_MUL_D) begin
				prev_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dir_q <= direction;
			depth_q <= cut_depth;
			err_q <= load_err;
			active_q <= auto_mode && link_ok && (direction != dpvd_pkg::DIR_IDLE);
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		unique case (cmd.op)
			dpvd_pkg::OP_MUL_D: acc_q <= (ACC_W'(prod_q) <<< P_SH) + ACC_W'(integ_q);
			dpvd_pkg::OP_SCALE: tot_q <= (acc_w <<< 5) + (acc_w <<< 4) + (acc_w <<< 1);
			dpvd_pkg::OP_TOTAL: tot_q <= tot_q + (TOT_W'(prod_q) <<< Q_SH);
			dpvd_pkg::OP_SAT: begin
				sat_q <= (tot_q > dpvd_pkg::TOT_MAX) || (tot_q < -dpvd_pkg::TOT_MAX);
				neg_q <= tot_q[TOT_W-1];
				x_q <= tot_abs[X_W+Q_SH-1:Q_SH];
			end
			dpvd_pkg::OP_DIV_Q: begin
				if (sat_q) begin
					t_q <= neg_q ? -T_LIM : T_LIM;
				end else begin
					t_q <= neg_q ? -qc_s : qc_s;
				end
			end
			dpvd_pkg::OP_ABS: begin
				m_q <= prod_abs[M_W-1:0];
				pneg_q <= prod_q[PROD_W-1] ^ (dir_q == dpvd_pkg::DIR_LOWER);
			end
			dpvd_pkg::OP_DIV_R: qd_q <= prod_q[dpvd_pkg::RECIP_LIM_SH+Q_W-1:dpvd_pkg::RECIP_LIM_SH];
			dpvd_pkg::OP_CORR: qd_q <= qd_q + Q_W'(rl >= (M_W+1)'(dpvd_pkg::TOTAL_LIMIT));
			dpvd_pkg::OP_MAP: begin
				if (dir_q == dpvd_pkg::DIR_HOLD) begin
					code_q <= signed'(CODE_W'(dpvd_pkg::FLOAT_CODE));
				end else begin
					code_q <= start_s + (pneg_q ? -qd_s : qd_s);
				end
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			drive_code_q <= res_code;
			drive_write_q <= res_write;
		end
	end

	assign stat.active = active_q;
	assign drive_code = drive_code_q;
	assign drive_write = drive_write_q;
endmodule

// File: design/deadband_pid_valve_drive.sv
// Top level of the deadband PID valve drive.
//
// channel  side  handshake        payload
// tick     in    valid / ready    direction[1:0] auto_mode cut_depth[9:0] link_ok
// drive    out   valid / ready    drive_code[11:0] drive_write
// apb      cfg   psel / penable   paddr[4:0] pwdata[31:0] prdata[31:0] (pready tied high)
//
// After acceptance an active tick runs through fifteen datapath steps of the step sequencer
// on one shared 25x22 multiplier and its divide-by-constant corrections; an inactive one
// runs only the integral step. The result is loaded into the output register in the done step.
// Reset clears the integral, the previous error and the handshakes and loads default gains.
// The next tick is taken as soon as the result sits in the output register; a result
// that is not taken holds the sequencer in its final step.
`include "deadband_pid_valve_drive_macros.svh"

module deadband_pid_valve_drive (
	input  logic                        clk,
	input  logic                        arst_n,
	dpvd_tick_if.sink                   tick,
	dpvd_drive_if.source                drive,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dpvd_pkg::ADDR_W-1:0] paddr,
	input  logic [dpvd_pkg::DATA_W-1:0] pwdata,
	output logic [dpvd_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	dpvd_pkg::cfg_t  cfg;
	dpvd_pkg::cmd_t  cmd;
	dpvd_pkg::stat_t stat;

	dpvd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dpvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (drive.valid),
		.out_ready (drive.ready),
		.cmd       (cmd)
	);

	dpvd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.direction   (tick.direction),
		.auto_mode   (tick.auto_mode),
		.cut_depth   (tick.cut_depth),
		.link_ok     (tick.link_ok),
		.drive_code  (drive.drive_code),
		.drive_write (drive.drive_write)
	);

	`DPVD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, tick.valid && tick.ready, !tick.ready)
	`DPVD_ASSERT_SAME(a_hold_is_float, clk, arst_n, drive.valid && !drive.drive_write, drive.drive_code == dpvd_pkg::FLOAT_CODE)
	`DPVD_ASSERT_SAME(a_result_after_work, clk, arst_n, $rose(drive.valid), $past(!tick.ready))
endmodule
